// ----- src/tbd_pkg.sv -----
// shared types and constants of the triangle bucket downsampler
// no dependencies
package tbd_pkg;

  localparam int POS_W       = 12;
  localparam int IDX_W       = 11;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int QUOT_W      = 2 * POS_W;
  localparam int STORE_DEPTH = 2048;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_POINTS = 1'b1;

  localparam logic [CFG_W-1:0] RST_SAMPLE_COUNT  = 12'd2048;
  localparam logic [CFG_W-1:0] RST_TARGET_POINTS = 12'd256;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] j;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] steps;
  } div_req_t;

endpackage

// ----- src/tbd_ram.sv -----
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module tbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tbd_edge_div.sv -----
// bucket edge divider: floor(j * span / steps), one quotient bit per cycle
// depends on tbd_pkg
module tbd_edge_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tbd_pkg::div_req_t            req_i,
  output logic                         done_o,
  output logic [tbd_pkg::QUOT_W-1:0]   quot_o
);

  localparam int QW = tbd_pkg::QUOT_W;
  localparam int PW = tbd_pkg::POS_W;
  localparam int CW = $clog2(QW);

  logic [QW-1:0] dvd_q, dvd_d;
  logic [PW-1:0] den_q, den_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [PW:0]   trial;
  logic          fits;

  always_comb begin
    trial  = {rem_q, dvd_q[QW-1]};
    fits   = trial >= {1'b0, den_q};
    dvd_d  = dvd_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = QW'(req_i.j) * QW'(req_i.span);
      den_d  = req_i.steps;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? PW'(trial - {1'b0, den_q}) : trial[PW-1:0];
      dvd_d = {dvd_q[QW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ----- src/triangle_bucket_downsampler_unit.sv -----
// top level of the lttb downsampler: control sequencer, area datapath and result queue
// depends on tbd_pkg, tbd_ram and tbd_edge_div
//
// Samples go into a sample memory one item per cycle while in_stall_o is low; the
// positions kept by largest-triangle-three-buckets downsampling come out as
// result items, at most two per sample, the last of them flagged by run_last_o.
// The first sample of a frame in bucket mode holds the input while the shared
// bit-serial divider works out the first two bucket edges. When a sample
// completes a bucket, the bucket before it is walked through the memory's
// single read port, one stored sample at a time in the steps read, multiply
// and compare, then the divider finds the next edge; the last bucket of a
// frame needs no new edge. A 4-entry result queue lets input continue while
// results wait; input stalls while more than two results wait.
module triangle_bucket_downsampler_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tbd_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tbd_pkg::IDX_W-1:0]       kept_index_o,
  output logic                            run_last_o
);

  localparam int PW    = tbd_pkg::POS_W;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int DEPTH = tbd_pkg::STORE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SXW   = 2 * PW;
  localparam int SYW   = SW + PW;
  localparam int DXW   = 2 * PW + 1;
  localparam int DYW   = SW + PW + 1;
  localparam int M1W   = DXW + SW + 1;
  localparam int M2W   = DYW + PW + 1;
  localparam int AREAW = 2 * PW + SW + 3;
  localparam int MaxN  = (DEPTH > (1 << PW) - 1) ? (1 << PW) - 1 : DEPTH;
  localparam logic [PW-1:0] MAX_N = PW'(MaxN);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV1  = 4'd1;
  localparam logic [3:0] ST_DIV2  = 4'd2;
  localparam logic [3:0] ST_PREP  = 4'd3;
  localparam logic [3:0] ST_PREP2 = 4'd4;
  localparam logic [3:0] ST_SADDR = 4'd5;
  localparam logic [3:0] ST_SMUL  = 4'd6;
  localparam logic [3:0] ST_SCMP  = 4'd7;
  localparam logic [3:0] ST_CLOSE = 4'd8;
  localparam logic [3:0] ST_DIVC  = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0]              state_q, state_d;
  logic [PW-1:0]           sc_q, sc_d, tp_q, tp_d;
  logic [PW-1:0]           pos_q, pos_d;
  logic [PW-1:0]           p_q, p_d;
  logic                    plast_q, plast_d;
  logic [PW-1:0]           bn_q, bn_d;
  logic [PW-1:0]           bstart_q, bstart_d;
  logic [PW-1:0]           nbs_q, nbs_d;
  logic [PW-1:0]           nbe_q, nbe_d;
  logic [SXW-1:0]          sx_q, sx_d;
  logic signed [SYW-1:0]   sy_q, sy_d;
  logic [PW-1:0]           cnt_q, cnt_d;
  logic [PW-1:0]           pp_q, pp_d;
  logic signed [SW-1:0]    yp_q, yp_d;
  logic [SXW-1:0]          cpp_q, cpp_d;
  logic signed [SYW:0]     cyp_q, cyp_d;
  logic signed [DXW-1:0]   dx_q, dx_d;
  logic signed [DYW-1:0]   dy_q, dy_d;
  logic [PW-1:0]           end_q, end_d;
  logic [PW-1:0]           si_q, si_d;
  logic signed [SW-1:0]    yi_q, yi_d;
  logic signed [M1W-1:0]   m1_q, m1_d;
  logic signed [M2W-1:0]   m2_q, m2_d;
  logic                    first_q, first_d;
  logic [PW-1:0]           best_q, best_d;
  logic signed [SW-1:0]    bval_q, bval_d;
  logic [AREAW-1:0]        barea_q, barea_d;

  tbd_pkg::out_item_t      fifo_q [4];
  logic [1:0]              wptr_q, rptr_q;
  logic [2:0]              fcnt_q;
  logic                    push;
  tbd_pkg::out_item_t      push_item;
  logic                    pop;

  tbd_pkg::div_req_t       div_req;
  logic                    div_done;
  logic [tbd_pkg::QUOT_W-1:0] div_quot;

  logic [PW-1:0]           n, n_m1, t_m2, p, edge_val;
  logic                    in_acc, is_last, acc_hit, close_hit, bn_active;
  logic [PW-1:0]           cnt_new;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [SW-1:0]           ram_rdata;
  logic signed [SW:0]      yd;
  logic signed [PW:0]      pd;
  logic signed [AREAW-1:0] diff;
  logic [AREAW-1:0]        mag;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign pop      = out_valid_o && !out_stall_i;
  assign n        = (sc_q < PW'(2)) ? PW'(2) : ((sc_q > MAX_N) ? MAX_N : sc_q);
  assign n_m1     = n - 1'b1;
  assign t_m2     = tp_q - PW'(2);
  assign p        = (pos_q >= n) ? '0 : pos_q;
  assign is_last  = p == n_m1;
  assign bn_active = bn_q < t_m2;
  assign acc_hit  = p >= nbs_q;
  assign cnt_new  = cnt_q + PW'(acc_hit);
  assign close_hit = bn_active && ({1'b0, p} + 1'b1 == {1'b0, nbe_q}) && (cnt_new != '0);
  assign edge_val = (div_quot >= tbd_pkg::QUOT_W'(n)) ? n : PW'(div_quot + 1'b1);

  assign ram_we    = in_acc;
  assign ram_waddr = AW'(p);
  assign ram_raddr = AW'(si_q);

  tbd_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tbd_edge_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    yd   = {ram_rdata[SW-1], ram_rdata} - {yp_q[SW-1], yp_q};
    pd   = $signed({1'b0, pp_q}) - $signed({1'b0, si_q});
    diff = AREAW'(m1_q) - AREAW'(m2_q);
    mag  = diff[AREAW-1] ? AREAW'(-diff) : AREAW'(diff);
  end

  always_comb begin
    state_d  = state_q;
    sc_d     = sc_q;
    tp_d     = tp_q;
    pos_d    = pos_q;
    p_d      = p_q;
    plast_d  = plast_q;
    bn_d     = bn_q;
    bstart_d = bstart_q;
    nbs_d    = nbs_q;
    nbe_d    = nbe_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    cnt_d    = cnt_q;
    pp_d     = pp_q;
    yp_d     = yp_q;
    cpp_d    = cpp_q;
    cyp_d    = cyp_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    end_d    = end_q;
    si_d     = si_q;
    yi_d     = yi_q;
    m1_d     = m1_q;
    m2_d     = m2_q;
    first_d  = first_q;
    best_d   = best_q;
    bval_d   = bval_q;
    barea_d  = barea_q;
    push     = 1'b0;
    push_item.idx  = tbd_pkg::IDX_W'(p);
    push_item.last = 1'b1;
    div_req.start = 1'b0;
    div_req.j     = '0;
    div_req.span  = n - PW'(2);
    div_req.steps = t_m2;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        tbd_pkg::REG_SAMPLE_COUNT:  sc_d = cfg_wdata_i;
        tbd_pkg::REG_TARGET_POINTS: tp_d = cfg_wdata_i;
        default: ;
      endcase
      pos_d = '0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          p_d     = p;
          plast_d = is_last;
          pos_d   = is_last ? '0 : p + 1'b1;
          if (tp_q >= n) begin
            push = 1'b1;
          end else if (tp_q < PW'(3)) begin
            push = (p == '0) || is_last;
          end else if (p == '0) begin
            push     = 1'b1;
            pp_d     = '0;
            yp_d     = sample_i;
            bn_d     = '0;
            bstart_d = PW'(1);
            sx_d     = '0;
            sy_d     = '0;
            cnt_d    = '0;
            div_req.start = 1'b1;
            div_req.j     = PW'(1);
            state_d  = ST_DIV1;
          end else begin
            if (bn_active) begin
              if (acc_hit) begin
                sx_d = sx_q + SXW'(p);
                sy_d = sy_q + SYW'(sample_i);
              end
              cnt_d = cnt_new;
            end
            if (close_hit) begin
              state_d = ST_PREP;
            end else begin
              push = is_last;
            end
          end
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          nbs_d = edge_val;
          div_req.start = 1'b1;
          div_req.j     = PW'(2);
          state_d = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          nbe_d   = edge_val;
          state_d = ST_IDLE;
        end
      end
      ST_PREP: begin
        cpp_d   = SXW'(cnt_q) * SXW'(pp_q);
        cyp_d   = $signed({1'b0, cnt_q}) * (SYW + 1)'(yp_q);
        end_d   = (nbs_q < n_m1) ? nbs_q : n_m1;
        state_d = ST_PREP2;
      end
      ST_PREP2: begin
        dx_d    = $signed({1'b0, cpp_q}) - $signed({1'b0, sx_q});
        dy_d    = DYW'(sy_q) - DYW'(cyp_q);
        si_d    = bstart_q;
        first_d = 1'b1;
        state_d = ST_SADDR;
      end
      ST_SADDR: begin
        state_d = ST_SMUL;
      end
      ST_SMUL: begin
        yi_d    = $signed(ram_rdata);
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        m1_d = m1_q;
        if (first_q || mag > barea_q) begin
          best_d  = si_q;
          bval_d  = yi_q;
          barea_d = mag;
        end
        first_d = 1'b0;
        if (si_q + 1'b1 < end_q) begin
          si_d    = si_q + 1'b1;
          state_d = ST_SADDR;
        end else begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        push           = 1'b1;
        push_item.idx  = tbd_pkg::IDX_W'(best_q);
        push_item.last = !plast_q;
        pp_d     = best_q;
        yp_d     = bval_q;
        bn_d     = bn_q + 1'b1;
        bstart_d = nbs_q;
        nbs_d    = nbe_q;
        sx_d     = '0;
        sy_d     = '0;
        cnt_d    = '0;
        if (bn_q + 1'b1 < t_m2) begin
          div_req.start = 1'b1;
          div_req.j     = bn_q + PW'(3);
          state_d = ST_DIVC;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIVC: begin
        if (div_done) begin
          nbe_d   = edge_val;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        push           = plast_q;
        push_item.idx  = tbd_pkg::IDX_W'(p_q);
        push_item.last = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (state_q == ST_SMUL) begin
      m1_d = M1W'(dx_q) * M1W'(yd);
      m2_d = M2W'(pd) * M2W'(dy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sc_q     <= tbd_pkg::RST_SAMPLE_COUNT;
      tp_q     <= tbd_pkg::RST_TARGET_POINTS;
      pos_q    <= '0;
      bn_q     <= '0;
      bstart_q <= PW'(1);
      nbs_q    <= '0;
      nbe_q    <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      cnt_q    <= '0;
      pp_q     <= '0;
      yp_q     <= '0;
      first_q  <= 1'b0;
      plast_q  <= 1'b0;
      wptr_q   <= '0;
      rptr_q   <= '0;
      fcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      sc_q     <= sc_d;
      tp_q     <= tp_d;
      pos_q    <= pos_d;
      bn_q     <= bn_d;
      bstart_q <= bstart_d;
      nbs_q    <= nbs_d;
      nbe_q    <= nbe_d;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      cnt_q    <= cnt_d;
      pp_q     <= pp_d;
      yp_q     <= yp_d;
      first_q  <= first_d;
      plast_q  <= plast_d;
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      fcnt_q <= fcnt_q + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    cpp_q   <= cpp_d;
    cyp_q   <= cyp_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    end_q   <= end_d;
    si_q    <= si_d;
    yi_q    <= yi_d;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    best_q  <= best_d;
    bval_q  <= bval_d;
    barea_q <= barea_d;
    if (push) begin
      fifo_q[wptr_q] <= push_item;
    end
  end

  assign in_stall_o   = !((state_q == ST_IDLE) && (fcnt_q <= 3'd2));
  assign out_valid_o  = fcnt_q != '0;
  assign kept_index_o = fifo_q[rptr_q].idx;
  assign run_last_o   = fifo_q[rptr_q].last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= 3'd4)
    else $error("result queue overflow");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE)
    else $error("item taken while sequencer busy");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2 || state_q == ST_DIVC))
    else $error("divider result with nobody waiting");

  a_best_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLOSE |-> best_q >= bstart_q)
    else $error("kept index before bucket start");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && fcnt_q == 3'd4) |-> pop)
    else $error("push into full result queue");

endmodule

// ----- sim/tb.sv -----
// testbench for triangle_bucket_downsampler_unit: drives sample items, predicts kept indices
// depends on tbd_pkg and the rtl of triangle_bucket_downsampler_unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX = 2048;

  logic clk, rst_n;
  logic cfg_we;
  logic [tbd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tbd_pkg::CFG_W-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic signed [15:0] sample;
  logic out_valid, out_stall;
  logic [tbd_pkg::IDX_W-1:0] kept_index;
  logic run_last;

  triangle_bucket_downsampler_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .sample_i(sample),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kept_index_o(kept_index), .run_last_o(run_last)
  );

  // predictor state
  int store_mem[NMAX];
  int unsigned frame_pos, bkt_num, bkt_start, next_end, next_cnt, kept_pos, cfg_n, cfg_t;
  longint sum_val, sum_pos;
  int kept_val;
  tbd_pkg::out_item_t kept_q[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #18_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned bucket_edge(int unsigned j, int unsigned n, int unsigned t);
    longint unsigned q;
    q = (longint'(j) * longint'(n - 2)) / longint'(t - 2);
    return int'(q) + 1;
  endfunction

  function automatic tbd_pkg::out_item_t mk_item(int unsigned idx);
    tbd_pkg::out_item_t it;
    it.idx = tbd_pkg::IDX_W'(idx);
    it.last = 1'b0;
    return it;
  endfunction

  function automatic void restart_frame();
    frame_pos = 0; bkt_num = 0; bkt_start = 1; next_end = 0; next_cnt = 0;
    sum_val = 0; sum_pos = 0; kept_pos = 0; kept_val = 0;
  endfunction

  function automatic void predict_kept(int v);
    int unsigned n, t, p, nbs, lim, best, i;
    longint c, pp, yp, dx, dy, a, best_area;
    tbd_pkg::out_item_t r[$];
    n = cfg_n < 2 ? 2 : (cfg_n > NMAX ? NMAX : cfg_n);
    t = cfg_t;
    p = frame_pos >= n ? 0 : frame_pos;
    store_mem[p] = v;
    if (t >= n) begin
      r = {r, mk_item(p)};
    end else if (t < 3) begin
      if (p == 0 || p == n - 1) begin
        r = {r, mk_item(p)};
      end
    end else if (p == 0) begin
      restart_frame();
      kept_val = v;
      next_end = bucket_edge(2, n, t);
      if (next_end > n) next_end = n;
      r = {r, mk_item(0)};
    end else begin
      if (bkt_num < t - 2) begin
        nbs = bucket_edge(bkt_num + 1, n, t);
        if (p >= nbs) begin
          sum_val += v; sum_pos += p; next_cnt++;
        end
        if (p + 1 == next_end && next_cnt > 0) begin
          c = next_cnt; pp = kept_pos; yp = kept_val;
          dx = c * pp - sum_pos;
          dy = sum_val - c * yp;
          lim = nbs < n - 1 ? nbs : n - 1;
          best = bkt_start;
          best_area = -1;
          for (i = bkt_start; i < lim; i++) begin
            a = dx * (longint'(store_mem[i]) - yp) - (pp - longint'(i)) * dy;
            if (a < 0) a = -a;
            if (a > best_area) begin
              best_area = a; best = i;
            end
          end
          r = {r, mk_item(best)};
          kept_pos = best; kept_val = store_mem[best];
          bkt_num++; bkt_start = nbs;
          sum_val = 0; sum_pos = 0; next_cnt = 0;
          if (bkt_num < t - 2) begin
            next_end = bucket_edge(bkt_num + 2, n, t);
            if (next_end > n) next_end = n;
          end
        end
      end
      if (p == n - 1) begin
        r = {r, mk_item(p)};
      end
    end
    if (r.size() > 0) r[r.size() - 1].last = 1'b1;
    kept_q = {kept_q, r};
    if (p + 1 >= n) restart_frame();
    else frame_pos = p + 1;
  endfunction

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // result checker
  initial begin
    tbd_pkg::out_item_t got, want;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.idx = kept_index;
        got.last = run_last;
        @(negedge clk);
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected item idx=%0d last=%0d", $time, got.idx, got.last);
          errors++;
        end else begin
          want = kept_q.pop_front();
          if (got.idx !== want.idx) begin
            $display("%0t: kept_index expected %0d actual %0d", $time, want.idx, got.idx);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: run_last expected %0d actual %0d", $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_sample(int v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= v[15:0];
    do @(posedge clk); while (in_stall);
    predict_kept(v);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [tbd_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[tbd_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == tbd_pkg::REG_SAMPLE_COUNT) cfg_n = val[tbd_pkg::CFG_W-1:0];
    else cfg_t = val[tbd_pkg::CFG_W-1:0];
    restart_frame();
  endtask

  task automatic set_frame(int unsigned n, int unsigned t);
    drain();
    write_reg(tbd_pkg::REG_SAMPLE_COUNT, n);
    write_reg(tbd_pkg::REG_TARGET_POINTS, t);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(9))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(3) - 1;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic test_pass_through();
    set_frame(4, 4);
    send_sample(-32768); send_sample(32767); send_sample(0); send_sample(-1);
  endtask

  task automatic test_small_target();
    set_frame(5, 0);
    repeat (5) send_sample(rand_sample());
    set_frame(2, 2);
    send_sample(-32768); send_sample(32767);
  endtask

  task automatic test_buckets();
    set_frame(10, 5);
    repeat (5) send_sample(100);
    send_sample(-32768); send_sample(32767); send_sample(-5); send_sample(7); send_sample(0);
  endtask

  task automatic test_extremes();
    set_frame(4095, 1000);
    repeat (60) send_sample(rand_sample());
    set_frame(0, 4095);
    repeat (3) send_sample(rand_sample());
    set_frame(2048, 2047);
    repeat (60) send_sample(rand_sample());
  endtask

  task automatic test_backpressure();
    set_frame(12, 12);
    hold_cycles = 400;
    repeat (40) send_sample(rand_sample());
  endtask

  task automatic test_random(int s_pct, int r_pct);
    int sent;
    int unsigned n, t, len;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    sent = 0;
    while (sent < 100) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(2, 40);
      t = $urandom_range(n + 3);
      drain();
      if ($urandom_range(1)) write_reg(tbd_pkg::REG_SAMPLE_COUNT, n);
      else cfg_n = cfg_n;
      write_reg(tbd_pkg::REG_TARGET_POINTS, t);
      if (cfg_n != n) write_reg(tbd_pkg::REG_SAMPLE_COUNT, n);
      len = $urandom_range(1, 2) * n + (($urandom_range(3) == 0) ? $urandom_range(n) : 0);
      repeat (len) send_sample(rand_sample());
      sent += len;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = tbd_pkg::REG_SAMPLE_COUNT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    sample = '0;
    cfg_n = tbd_pkg::RST_SAMPLE_COUNT;
    cfg_t = tbd_pkg::RST_TARGET_POINTS;
    restart_frame();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_pass_through();
    test_small_target();
    test_buckets();
    test_random(32, 81);
    test_random(81, 32);
    test_random(0, 0);
    test_backpressure();
    test_extremes();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
